// ----- sv/hvqe_pkg.sv -----
// Shared constants, widths, the arctangent table and the half-precision converter.
package hvqe_pkg;

	localparam int FRAC_BITS    = 14;
	localparam int CORDIC_STEPS = 16;

	localparam int HALF_W   = 16;
	localparam int FIX_W    = FRAC_BITS + 3;
	localparam int SQ_W     = 2 * FRAC_BITS + 3;
	localparam int SUM_W    = 2 * FRAC_BITS + 4;
	localparam int SQRT_LAT = SUM_W / 2;
	localparam int ROOT_W   = FRAC_BITS + 3;
	localparam int REM_W    = ROOT_W + 3;
	localparam int DVD_W    = 2 * FRAC_BITS + 2;
	localparam int Q_W      = FRAC_BITS + 2;
	localparam int DIV_LAT  = Q_W;
	localparam int DCMP_W   = ROOT_W + Q_W;
	localparam int PART_W   = FRAC_BITS + 2;
	localparam int W_W      = FRAC_BITS + 1;
	localparam int PROD_W   = 2 * PART_W;
	localparam int OP_W     = PROD_W + 2;
	localparam int SF_W     = FRAC_BITS + 2;
	localparam int CW       = 2 * FRAC_BITS + 7;
	localparam int ZW       = 32;
	localparam int ANG_W    = 16;
	localparam int PITCH_W  = 15;
	localparam int QUAT_W   = 16;
	localparam int QUAT_W_W = 15;
	localparam int CORDIC_LAT = CORDIC_STEPS + 2;

	localparam int ONE_F = 1 << FRAC_BITS;
	localparam logic [SUM_W-1:0] ONE_2F = SUM_W'(1) << (2 * FRAC_BITS);
	localparam longint DEGEN_LIMIT = ((longint'(1) << (2 * FRAC_BITS)) + 999999) / 1000000;
	localparam logic [63:0] SAT_MAG = 64'd2 << FRAC_BITS;

	localparam logic signed [ZW-1:0] DEG180      = 188743680;
	localparam logic signed [ZW-1:0] ANG_LIMIT   = 23040;
	localparam logic signed [ZW-1:0] PITCH_LIMIT = 11520;
	localparam logic signed [ZW-1:0] ANG_ROUND   = 4096;
	localparam int ANG_SHIFT = 13;

	localparam logic signed [ZW-1:0] ATAN_TAB [24] = '{
		47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
		234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
		917, 458, 229, 115, 57, 29, 14, 7
	};

	function automatic logic signed [FIX_W-1:0] half_to_fix(input logic [HALF_W-1:0] h);
		logic [4:0] ex;
		logic [63:0] m;
		logic [63:0] mag;
		int sh;
		ex = h[14:10];
		m = {54'd0, h[9:0]};
		mag = '0;
		sh = 0;
		if (ex == 5'd31) begin
			mag = SAT_MAG;
		end else begin
			if (ex == 5'd0) begin
				ex = 5'd1;
			end else begin
				m[10] = 1'b1;
			end
			sh = int'(ex) - 25 + FRAC_BITS;
			if (sh >= 0) begin
				mag = m << sh;
			end else begin
				mag = (m + (64'd1 << (-sh - 1))) >> (-sh);
			end
			if (mag > SAT_MAG) begin
				mag = SAT_MAG;
			end
		end
		if (h[15]) begin
			return FIX_W'(-mag);
		end
		return FIX_W'(mag);
	endfunction

endpackage

// ----- sv/hvqe_if.sv -----
// Stream interfaces for the input sample beats and the result beats.
interface hvqe_in_if import hvqe_pkg::*; ();
	logic valid;
	logic ready;
	logic [HALF_W-1:0] x_half;
	logic [HALF_W-1:0] y_half;
	logic [HALF_W-1:0] z_half;
	modport source(output valid, output x_half, output y_half, output z_half, input ready);
	modport sink(input valid, input x_half, input y_half, input z_half, output ready);
endinterface

interface hvqe_out_if import hvqe_pkg::*; ();
	logic valid;
	logic ready;
	logic signed [QUAT_W-1:0] quat_x;
	logic signed [QUAT_W-1:0] quat_y;
	logic signed [QUAT_W-1:0] quat_z;
	logic [QUAT_W_W-1:0] quat_w;
	logic signed [ANG_W-1:0] roll_angle;
	logic signed [PITCH_W-1:0] pitch_angle;
	logic signed [ANG_W-1:0] yaw_angle;
	logic degenerate;
	logic rescaled;
	modport source(output valid, output quat_x, output quat_y, output quat_z, output quat_w,
		output roll_angle, output pitch_angle, output yaw_angle, output degenerate,
		output rescaled, input ready);
	modport sink(input valid, input quat_x, input quat_y, input quat_z, input quat_w,
		input roll_angle, input pitch_angle, input yaw_angle, input degenerate,
		input rescaled, output ready);
endinterface

// ----- sv/hvqe_sqrt.sv -----
// Pipelined integer square root, one result bit per stage, rounded to nearest.
module hvqe_sqrt import hvqe_pkg::*; (
	input  logic              clk,
	input  logic              en,
	input  logic [SUM_W-1:0]  op,
	output logic [ROOT_W-1:0] root
);

	logic [SUM_W-1:0]  op_q   [SQRT_LAT];
	logic [REM_W-1:0]  rem_q  [SQRT_LAT];
	logic [ROOT_W-1:0] root_q [SQRT_LAT];

	for (genvar i = 0; i < SQRT_LAT; i++) begin : g_step
		logic [SUM_W-1:0]  op_in;
		logic [REM_W-1:0]  rem_in;
		logic [ROOT_W-1:0] root_in;
		logic [REM_W-1:0]  rem_sh;
		logic [REM_W-1:0]  trial;
		if (i == 0) begin : g_first
			assign op_in   = op;
			assign rem_in  = '0;
			assign root_in = '0;
		end else begin : g_next
			assign op_in   = op_q[i-1];
			assign rem_in  = rem_q[i-1];
			assign root_in = root_q[i-1];
		end
		assign rem_sh = {rem_in[REM_W-3:0], op_in[SUM_W-1 -: 2]};
		assign trial  = REM_W'({root_in, 2'b01});
		always_ff @(posedge clk) begin
			if (en) begin
				op_q[i] <= op_in << 2;
				if (rem_sh >= trial) begin
					rem_q[i]  <= rem_sh - trial;
					root_q[i] <= {root_in[ROOT_W-2:0], 1'b1};
				end else begin
					rem_q[i]  <= rem_sh;
					root_q[i] <= {root_in[ROOT_W-2:0], 1'b0};
				end
			end
		end
	end

	assign root = (rem_q[SQRT_LAT-1] > REM_W'(root_q[SQRT_LAT-1])) ?
		root_q[SQRT_LAT-1] + ROOT_W'(1) : root_q[SQRT_LAT-1];

endmodule

// ----- sv/hvqe_div.sv -----
// Pipelined restoring divider, one quotient bit per stage.
module hvqe_div import hvqe_pkg::*; (
	input  logic              clk,
	input  logic              en,
	input  logic [DVD_W-1:0]  dividend,
	input  logic [ROOT_W-1:0] divisor,
	output logic [Q_W-1:0]    quotient
);

	logic [DCMP_W-1:0] rem_q [DIV_LAT];
	logic [ROOT_W-1:0] d_q   [DIV_LAT];
	logic [Q_W-1:0]    q_q   [DIV_LAT];

	for (genvar i = 0; i < DIV_LAT; i++) begin : g_step
		localparam int B = Q_W - 1 - i;
		logic [DCMP_W-1:0] rem_in;
		logic [ROOT_W-1:0] d_in;
		logic [Q_W-1:0]    q_in;
		logic [DCMP_W-1:0] shifted;
		logic              ge;
		if (i == 0) begin : g_first
			assign rem_in = DCMP_W'(dividend);
			assign d_in   = divisor;
			assign q_in   = '0;
		end else begin : g_next
			assign rem_in = rem_q[i-1];
			assign d_in   = d_q[i-1];
			assign q_in   = q_q[i-1];
		end
		assign shifted = DCMP_W'(d_in) << B;
		assign ge      = rem_in >= shifted;
		always_ff @(posedge clk) begin
			if (en) begin
				d_q[i]   <= d_in;
				rem_q[i] <= ge ? rem_in - shifted : rem_in;
				q_q[i]   <= {q_in[Q_W-2:0], ge};
			end
		end
	end

	assign quotient = q_q[DIV_LAT-1];

endmodule

// ----- sv/hvqe_cordic.sv -----
// Pipelined vectoring CORDIC giving atan2 in 1/128 degree, clamped to a half turn.
module hvqe_cordic import hvqe_pkg::*; (
	input  logic                    clk,
	input  logic                    en,
	input  logic signed [CW-1:0]    y,
	input  logic signed [CW-1:0]    x,
	output logic signed [ANG_W-1:0] angle
);

	logic signed [CW-1:0] x_q [CORDIC_STEPS+1];
	logic signed [CW-1:0] y_q [CORDIC_STEPS+1];
	logic signed [ZW-1:0] z_q [CORDIC_STEPS+1];
	logic                 zero_q [CORDIC_STEPS+1];
	logic signed [ZW-1:0] zr;
	logic signed [ZW-1:0] zc;
	logic signed [ANG_W-1:0] angle_q;

	always_ff @(posedge clk) begin
		if (en) begin
			zero_q[0] <= (x == '0) && (y == '0);
			if (x < 0) begin
				x_q[0] <= -x;
				y_q[0] <= -y;
				z_q[0] <= (y >= 0) ? DEG180 : -DEG180;
			end else begin
				x_q[0] <= x;
				y_q[0] <= y;
				z_q[0] <= '0;
			end
		end
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
		always_ff @(posedge clk) begin
			if (en) begin
				zero_q[i+1] <= zero_q[i];
				if (y_q[i][CW-1]) begin
					x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
					y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
					z_q[i+1] <= z_q[i] - ATAN_TAB[i];
				end else begin
					x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
					y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
					z_q[i+1] <= z_q[i] + ATAN_TAB[i];
				end
			end
		end
	end

	always_comb begin
		zr = (z_q[CORDIC_STEPS] + ANG_ROUND) >>> ANG_SHIFT;
		if (zr > ANG_LIMIT) begin
			zc = ANG_LIMIT;
		end else if (zr < -ANG_LIMIT) begin
			zc = -ANG_LIMIT;
		end else begin
			zc = zr;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			angle_q <= zero_q[CORDIC_STEPS] ? '0 : ANG_W'(zc);
		end
	end

	assign angle = angle_q;

endmodule

// ----- sv/half_vector_quaternion_to_euler_core.sv -----
// Top level: half-precision quaternion vector to full quaternion and Euler angles.
// The block accepts one sample beat in every cycle unless the result side stalls, and
// returns one result beat for each, in order. The pipeline is made of the square-root
// pipeline for the scalar part or the vector length (16 stages), the 16-stage dividers that
// rescale long vectors, a second 16-stage square root for the pitch cosine and the 18-stage
// CORDIC units, plus ten stages of conversion and products. When the result side stalls,
// the whole pipeline holds, so no beat is lost or repeated.
module half_vector_quaternion_to_euler_core import hvqe_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	hvqe_in_if.sink      samples,
	hvqe_out_if.source   results
);

	localparam int LAT = 10 + 2 * SQRT_LAT + DIV_LAT + CORDIC_LAT;

	typedef struct packed {
		logic signed [FIX_W-1:0] x;
		logic signed [FIX_W-1:0] y;
		logic signed [FIX_W-1:0] z;
	} vec_t;

	typedef struct packed {
		vec_t            v;
		logic [SQ_W-1:0] xx;
		logic [SQ_W-1:0] yy;
		logic [SQ_W-1:0] zz;
	} sq_t;

	typedef struct packed {
		vec_t v;
		logic degen;
		logic lng;
	} side4_t;

	typedef struct packed {
		side4_t            sd;
		logic [ROOT_W-1:0] root;
	} side6_t;

	typedef struct packed {
		logic signed [PART_W-1:0] x;
		logic signed [PART_W-1:0] y;
		logic signed [PART_W-1:0] z;
		logic [W_W-1:0]           w;
		logic                     degen;
		logic                     lng;
	} quat_t;

	typedef struct packed {
		logic signed [PROD_W-1:0] wx;
		logic signed [PROD_W-1:0] yz;
		logic signed [PROD_W-1:0] wz;
		logic signed [PROD_W-1:0] xy;
		logic signed [PROD_W-1:0] wy;
		logic signed [PROD_W-1:0] zx;
		logic signed [PROD_W-1:0] xx;
		logic signed [PROD_W-1:0] yy;
		logic signed [PROD_W-1:0] zz;
	} prod_t;

	typedef struct packed {
		logic signed [OP_W-1:0] roll_y;
		logic signed [OP_W-1:0] roll_x;
		logic signed [OP_W-1:0] yaw_y;
		logic signed [OP_W-1:0] yaw_x;
	} ops_t;

	typedef struct packed {
		logic signed [SF_W-1:0] sf;
		logic                   sat_p;
		logic                   sat_n;
	} pitch_t;

	typedef struct packed {
		quat_t  q;
		ops_t   ops;
		pitch_t p;
	} side12_t;

	typedef struct packed {
		logic signed [CW-1:0] roll_y;
		logic signed [CW-1:0] roll_x;
		logic signed [CW-1:0] yaw_y;
		logic signed [CW-1:0] yaw_x;
		logic signed [CW-1:0] pit_y;
		logic signed [CW-1:0] pit_x;
	} cin_t;

	typedef struct packed {
		quat_t q;
		logic  sat_p;
		logic  sat_n;
	} side14_t;

	logic           en;
	logic [LAT-1:0] vld_q;

	vec_t              conv_s1;
	sq_t               sq_s2;
	side4_t            sum_s3;
	logic [SUM_W-1:0]  sum_op_s3;
	logic [SUM_W-1:0]  sum;
	side4_t            sqd_s4 [SQRT_LAT];
	logic [ROOT_W-1:0] root1;
	side6_t            dvs_s5;
	logic [DVD_W-1:0]  dvd_s5 [3];
	side6_t            divd_s6 [DIV_LAT];
	logic [Q_W-1:0]    quo [3];
	quat_t             sel_s7;
	quat_t             q_s8;
	prod_t             prod_s8;
	logic signed [PART_W-1:0] ws;
	quat_t             q_s9;
	ops_t              ops_s9;
	logic signed [OP_W-1:0] sinp_s9;
	quat_t             q_s10;
	ops_t              ops_s10;
	pitch_t            pitch;
	pitch_t            pit_s10;
	logic signed [OP_W-1:0] sr;
	logic signed [2*SF_W-1:0] sfsq;
	side12_t           sq2_s11;
	logic [SUM_W-1:0]  op2_s11;
	side12_t           sqd_s12 [SQRT_LAT];
	logic [ROOT_W-1:0] root2;
	cin_t              cin_s13;
	side14_t           side_s13;
	side14_t           cld_s14 [CORDIC_LAT];
	logic signed [ANG_W-1:0] roll_raw;
	logic signed [ANG_W-1:0] yaw_raw;
	logic signed [ANG_W-1:0] pitch_raw;
	side14_t           fin;
	logic signed [PITCH_W-1:0] pc;

	function automatic logic [DVD_W-1:0] scaled_dividend(input logic signed [FIX_W-1:0] p,
		input logic [ROOT_W-1:0] n);
		logic [FIX_W-1:0] a;
		a = p[FIX_W-1] ? FIX_W'(-p) : FIX_W'(p);
		return (DVD_W'(a) << FRAC_BITS) + DVD_W'(n >> 1);
	endfunction

	function automatic logic signed [PART_W-1:0] pick_part(input logic lng,
		input logic signed [FIX_W-1:0] p, input logic [Q_W-1:0] q);
		logic [PART_W-1:0] qq;
		qq = PART_W'(q);
		if (!lng) begin
			return PART_W'(p);
		end
		return p[FIX_W-1] ? -qq : qq;
	endfunction

	assign en = !vld_q[LAT-1] || results.ready;
	assign samples.ready = en;
	assign results.valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], samples.valid};
		end
	end

	assign sum = SUM_W'(sq_s2.xx) + SUM_W'(sq_s2.yy) + SUM_W'(sq_s2.zz);

	always_ff @(posedge clk) begin
		if (en) begin
			conv_s1.x <= half_to_fix(samples.x_half);
			conv_s1.y <= half_to_fix(samples.y_half);
			conv_s1.z <= half_to_fix(samples.z_half);

			sq_s2.v  <= conv_s1;
			sq_s2.xx <= SQ_W'(conv_s1.x * conv_s1.x);
			sq_s2.yy <= SQ_W'(conv_s1.y * conv_s1.y);
			sq_s2.zz <= SQ_W'(conv_s1.z * conv_s1.z);

			sum_s3.v     <= sq_s2.v;
			sum_s3.degen <= sum < SUM_W'(DEGEN_LIMIT);
			sum_s3.lng   <= sum > ONE_2F;
			sum_op_s3    <= (sum > ONE_2F) ? sum : ONE_2F - sum;

			sqd_s4[0] <= sum_s3;
			for (int i = 1; i < SQRT_LAT; i++) begin
				sqd_s4[i] <= sqd_s4[i-1];
			end

			dvs_s5.sd   <= sqd_s4[SQRT_LAT-1];
			dvs_s5.root <= root1;
			dvd_s5[0]   <= scaled_dividend(sqd_s4[SQRT_LAT-1].v.x, root1);
			dvd_s5[1]   <= scaled_dividend(sqd_s4[SQRT_LAT-1].v.y, root1);
			dvd_s5[2]   <= scaled_dividend(sqd_s4[SQRT_LAT-1].v.z, root1);

			divd_s6[0] <= dvs_s5;
			for (int i = 1; i < DIV_LAT; i++) begin
				divd_s6[i] <= divd_s6[i-1];
			end

			sel_s7.x <= pick_part(divd_s6[DIV_LAT-1].sd.lng, divd_s6[DIV_LAT-1].sd.v.x, quo[0]);
			sel_s7.y <= pick_part(divd_s6[DIV_LAT-1].sd.lng, divd_s6[DIV_LAT-1].sd.v.y, quo[1]);
			sel_s7.z <= pick_part(divd_s6[DIV_LAT-1].sd.lng, divd_s6[DIV_LAT-1].sd.v.z, quo[2]);
			sel_s7.w <= divd_s6[DIV_LAT-1].sd.lng ? '0 : W_W'(divd_s6[DIV_LAT-1].root);
			sel_s7.degen <= divd_s6[DIV_LAT-1].sd.degen;
			sel_s7.lng   <= divd_s6[DIV_LAT-1].sd.lng;

			q_s8       <= sel_s7;
			prod_s8.wx <= ws * sel_s7.x;
			prod_s8.yz <= sel_s7.y * sel_s7.z;
			prod_s8.wz <= ws * sel_s7.z;
			prod_s8.xy <= sel_s7.x * sel_s7.y;
			prod_s8.wy <= ws * sel_s7.y;
			prod_s8.zx <= sel_s7.z * sel_s7.x;
			prod_s8.xx <= sel_s7.x * sel_s7.x;
			prod_s8.yy <= sel_s7.y * sel_s7.y;
			prod_s8.zz <= sel_s7.z * sel_s7.z;

			q_s9 <= q_s8;
			ops_s9.roll_y <= (OP_W'(prod_s8.wx) + OP_W'(prod_s8.yz)) <<< 1;
			ops_s9.roll_x <= $signed(OP_W'(ONE_2F)) -
				((OP_W'(prod_s8.xx) + OP_W'(prod_s8.yy)) <<< 1);
			ops_s9.yaw_y  <= (OP_W'(prod_s8.wz) + OP_W'(prod_s8.xy)) <<< 1;
			ops_s9.yaw_x  <= $signed(OP_W'(ONE_2F)) -
				((OP_W'(prod_s8.yy) + OP_W'(prod_s8.zz)) <<< 1);
			sinp_s9 <= (OP_W'(prod_s8.wy) - OP_W'(prod_s8.zx)) <<< 1;

			q_s10   <= q_s9;
			ops_s10 <= ops_s9;
			pit_s10 <= pitch;

			sq2_s11.q   <= q_s10;
			sq2_s11.ops <= ops_s10;
			sq2_s11.p   <= pit_s10;
			op2_s11     <= ONE_2F - SUM_W'(sfsq);

			sqd_s12[0] <= sq2_s11;
			for (int i = 1; i < SQRT_LAT; i++) begin
				sqd_s12[i] <= sqd_s12[i-1];
			end

			cin_s13.roll_y <= CW'(sqd_s12[SQRT_LAT-1].ops.roll_y);
			cin_s13.roll_x <= CW'(sqd_s12[SQRT_LAT-1].ops.roll_x);
			cin_s13.yaw_y  <= CW'(sqd_s12[SQRT_LAT-1].ops.yaw_y);
			cin_s13.yaw_x  <= CW'(sqd_s12[SQRT_LAT-1].ops.yaw_x);
			cin_s13.pit_y  <= CW'(sqd_s12[SQRT_LAT-1].p.sf);
			cin_s13.pit_x  <= CW'(root2);
			side_s13.q     <= sqd_s12[SQRT_LAT-1].q;
			side_s13.sat_p <= sqd_s12[SQRT_LAT-1].p.sat_p;
			side_s13.sat_n <= sqd_s12[SQRT_LAT-1].p.sat_n;

			cld_s14[0] <= side_s13;
			for (int i = 1; i < CORDIC_LAT; i++) begin
				cld_s14[i] <= cld_s14[i-1];
			end
		end
	end

	assign ws   = signed'({1'b0, sel_s7.w});
	assign sfsq = pit_s10.sf * pit_s10.sf;

	always_comb begin
		pitch.sat_p = sinp_s9 >= $signed(OP_W'(ONE_2F));
		pitch.sat_n = sinp_s9 <= -$signed(OP_W'(ONE_2F));
		sr = (sinp_s9 + OP_W'(ONE_F / 2)) >>> FRAC_BITS;
		if (sr > OP_W'(ONE_F)) begin
			pitch.sf = SF_W'(ONE_F);
		end else if (sr < -OP_W'(ONE_F)) begin
			pitch.sf = -SF_W'(ONE_F);
		end else begin
			pitch.sf = SF_W'(sr);
		end
	end

	hvqe_sqrt u_sqrt_len (.clk(clk), .en(en), .op(sum_op_s3), .root(root1));

	for (genvar k = 0; k < 3; k++) begin : g_div
		hvqe_div u_div (
			.clk(clk), .en(en), .dividend(dvd_s5[k]), .divisor(dvs_s5.root),
			.quotient(quo[k])
		);
	end

	hvqe_sqrt u_sqrt_cos (.clk(clk), .en(en), .op(op2_s11), .root(root2));

	hvqe_cordic u_roll (.clk(clk), .en(en), .y(cin_s13.roll_y), .x(cin_s13.roll_x),
		.angle(roll_raw));
	hvqe_cordic u_yaw (.clk(clk), .en(en), .y(cin_s13.yaw_y), .x(cin_s13.yaw_x),
		.angle(yaw_raw));
	hvqe_cordic u_pitch (.clk(clk), .en(en), .y(cin_s13.pit_y), .x(cin_s13.pit_x),
		.angle(pitch_raw));

	always_comb begin
		fin = cld_s14[CORDIC_LAT-1];
		priority if (fin.sat_p) begin
			pc = PITCH_W'(PITCH_LIMIT);
		end else if (fin.sat_n) begin
			pc = PITCH_W'(-PITCH_LIMIT);
		end else if (pitch_raw > PITCH_LIMIT) begin
			pc = PITCH_W'(PITCH_LIMIT);
		end else if (pitch_raw < -PITCH_LIMIT) begin
			pc = PITCH_W'(-PITCH_LIMIT);
		end else begin
			pc = PITCH_W'(pitch_raw);
		end
		if (fin.q.degen) begin
			results.quat_x      = '0;
			results.quat_y      = '0;
			results.quat_z      = '0;
			results.quat_w      = QUAT_W_W'(ONE_F);
			results.roll_angle  = '0;
			results.pitch_angle = '0;
			results.yaw_angle   = '0;
		end else begin
			results.quat_x      = QUAT_W'(fin.q.x);
			results.quat_y      = QUAT_W'(fin.q.y);
			results.quat_z      = QUAT_W'(fin.q.z);
			results.quat_w      = QUAT_W_W'(fin.q.w);
			results.roll_angle  = roll_raw;
			results.pitch_angle = pc;
			results.yaw_angle   = yaw_raw;
		end
		results.degenerate = fin.q.degen;
		results.rescaled   = fin.q.lng;
	end

endmodule

// ----- dv/tb_top.sv -----
// Testbench for the quaternion to Euler angle core: directed and random samples, scoreboarded.
module tb_top;
	import hvqe_pkg::*;

	typedef struct packed {
		logic signed [15:0] qx;
		logic signed [15:0] qy;
		logic signed [15:0] qz;
		logic [14:0] qw;
		logic signed [15:0] roll;
		logic signed [14:0] pitch;
		logic signed [15:0] yaw;
		logic degen;
		logic resc;
	} euler_t;

	localparam longint ONE1 = longint'(1) << FRAC_BITS;
	localparam longint ONE2 = longint'(1) << (2 * FRAC_BITS);
	localparam int STALL_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	hvqe_in_if samples();
	hvqe_out_if results();

	half_vector_quaternion_to_euler_core dut(.clk(clk), .arst_n(arst_n),
		.samples(samples.sink), .results(results.source));

	always #2 clk = ~clk;

	euler_t expected_q[$];
	int mismatches = 0;
	int idle_pct = 29;
	bit hold_results = 1'b0;
	int quiet_cycles = 0;

	function automatic longint fix_of_half(logic [15:0] h);
		longint e, m, mag, sh;
		e = h[14:10];
		m = h[9:0];
		if (e == 31) begin
			mag = ONE1 * 2;
		end else begin
			if (e == 0) e = 1;
			else m = m + 1024;
			sh = e - 25 + FRAC_BITS;
			if (sh >= 0) mag = m << sh;
			else mag = (m + (longint'(1) << (-sh - 1))) >> (-sh);
			if (mag > ONE1 * 2) mag = ONE1 * 2;
		end
		return h[15] ? -mag : mag;
	endfunction

	function automatic longint root_rnd(longint v);
		longint r;
		r = 0;
		while ((r + 1) * (r + 1) <= v) r++;
		if (v - r * r > r) r++;
		return r;
	endfunction

	function automatic longint floor_shift(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint angle_of(longint y, longint x);
		longint z, nx, r;
		z = 0;
		if (x == 0 && y == 0) return 0;
		if (x < 0) begin
			z = (y >= 0) ? longint'(DEG180) : -longint'(DEG180);
			x = -x;
			y = -y;
		end
		for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
			if (y < 0) begin
				nx = x - floor_shift(y, i);
				y = y + floor_shift(x, i);
				z -= longint'(ATAN_TAB[i]);
			end else begin
				nx = x + floor_shift(y, i);
				y = y - floor_shift(x, i);
				z += longint'(ATAN_TAB[i]);
			end
			x = nx;
		end
		r = floor_shift(z + 4096, 13);
		if (r > 23040) r = 23040;
		if (r < -23040) r = -23040;
		return r;
	endfunction

	function automatic longint unit_part(longint p, longint n);
		longint a, q;
		a = p < 0 ? -p : p;
		q = ((a << FRAC_BITS) + n / 2) / n;
		return p < 0 ? -q : q;
	endfunction

	function automatic euler_t predict_euler(logic [15:0] hx, logic [15:0] hy, logic [15:0] hz);
		longint x, y, z, w, s, n, sinp, sf, pitch;
		euler_t r;
		x = fix_of_half(hx);
		y = fix_of_half(hy);
		z = fix_of_half(hz);
		s = x * x + y * y + z * z;
		r = '0;
		if (s < DEGEN_LIMIT) begin
			r.qw = 15'(ONE1);
			r.degen = 1'b1;
			return r;
		end
		if (s > ONE2) begin
			n = root_rnd(s);
			x = unit_part(x, n);
			y = unit_part(y, n);
			z = unit_part(z, n);
			w = 0;
			r.resc = 1'b1;
		end else begin
			w = root_rnd(ONE2 - s);
		end
		sinp = 2 * (w * y - z * x);
		if (sinp >= ONE2) begin
			pitch = 11520;
		end else if (sinp <= -ONE2) begin
			pitch = -11520;
		end else begin
			sf = floor_shift(sinp + ONE1 / 2, FRAC_BITS);
			if (sf > ONE1) sf = ONE1;
			if (sf < -ONE1) sf = -ONE1;
			pitch = angle_of(sf, root_rnd(ONE2 - sf * sf));
			if (pitch > 11520) pitch = 11520;
			if (pitch < -11520) pitch = -11520;
		end
		r.qx = 16'(x);
		r.qy = 16'(y);
		r.qz = 16'(z);
		r.qw = 15'(w);
		r.roll = 16'(angle_of(2 * (w * x + y * z), ONE2 - 2 * (x * x + y * y)));
		r.pitch = 15'(pitch);
		r.yaw = 16'(angle_of(2 * (w * z + x * y), ONE2 - 2 * (y * y + z * z)));
		return r;
	endfunction

	initial begin
		samples.valid = 1'b0;
		samples.x_half = '0;
		samples.y_half = '0;
		samples.z_half = '0;
		results.ready = 1'b0;
	end

	always @(posedge clk) begin
		if (hold_results) results.ready <= 1'b0;
		else results.ready <= ($urandom_range(99) >= idle_pct);
	end

	always @(posedge clk) begin
		euler_t got, want;
		if (arst_n && results.valid && results.ready) begin
			got = '{results.quat_x, results.quat_y, results.quat_z, results.quat_w,
				results.roll_angle, results.pitch_angle, results.yaw_angle,
				results.degenerate, results.rescaled};
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("Unexpected result beat %p", got);
			end else begin
				want = expected_q.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10) $display("Mismatch: expected %p, got %p", want, got);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((samples.valid && samples.ready) || (results.valid && results.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > STALL_LIMIT) begin
			$display("FAIL half_vector_quaternion_to_euler_core");
			$finish;
		end
	end

	task automatic send_sample(logic [15:0] hx, logic [15:0] hy, logic [15:0] hz);
		while ($urandom_range(99) < idle_pct) begin
			samples.valid <= 1'b0;
			@(posedge clk);
		end
		samples.valid <= 1'b1;
		samples.x_half <= hx;
		samples.y_half <= hy;
		samples.z_half <= hz;
		do @(posedge clk); while (!samples.ready);
		expected_q.push_back(predict_euler(hx, hy, hz));
	endtask

	task automatic stop_sending();
		samples.valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (expected_q.size() != 0) @(posedge clk);
	endtask

	function automatic logic [15:0] unit_half();
		logic [15:0] h;
		h = 16'($urandom_range(65535));
		h[14:10] = 5'($urandom_range(5, 14));
		return h;
	endfunction

	task automatic test_directed();
		logic [15:0] corners[10] = '{16'h0000, 16'h8000, 16'h0001, 16'h83ff, 16'h3c00,
			16'hbc00, 16'h7bff, 16'h7c00, 16'hfe00, 16'h3800};
		for (int i = 0; i < 10; i++) send_sample(corners[i], corners[9 - i], corners[(i + 3) % 10]);
		send_sample(16'h3c00, 16'h0000, 16'h0000);
		send_sample(16'h0000, 16'h3c00, 16'h0000);
		send_sample(16'h0000, 16'hbc00, 16'h0000);
		send_sample(16'h39a8, 16'h0000, 16'h39a8);
		send_sample(16'h0000, 16'h39a8, 16'h39a8);
		send_sample(16'h0010, 16'h0010, 16'h0010);
		send_sample(16'h1400, 16'h0000, 16'h0000);
		send_sample(16'h3800, 16'h3800, 16'h3800);
		send_sample(16'h3800, 16'hb800, 16'h3800);
		stop_sending();
	endtask

	task automatic test_random();
		for (int i = 0; i < 310; i++) begin
			idle_pct = (i >= 150 && i < 250) ? 0 : 29;
			case ($urandom_range(3))
				0: send_sample(16'($urandom), 16'($urandom), 16'($urandom));
				1: send_sample(unit_half(), 16'($urandom_range(4096)), unit_half());
				default: send_sample(unit_half(), unit_half(), unit_half());
			endcase
		end
		idle_pct = 29;
	endtask

	task automatic test_backpressure();
		fork
			begin
				hold_results = 1'b1;
				repeat (300) @(posedge clk);
				hold_results = 1'b0;
			end
			begin
				for (int i = 0; i < 120; i++) send_sample(unit_half(), unit_half(), unit_half());
				stop_sending();
			end
		join
		wait_drained();
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		wait_drained();
		test_random();
		test_backpressure();
		wait_drained();
		repeat (100) @(posedge clk);
		if (mismatches == 0 && expected_q.size() == 0) begin
			$display("PASS half_vector_quaternion_to_euler_core");
		end else begin
			$display("FAIL half_vector_quaternion_to_euler_core");
		end
		$finish;
	end
endmodule
